// ===== src/lrwc_pkg.sv =====
// Shared types and constants for the line raster window command block.
`default_nettype none

package lrwc_pkg;

  localparam logic       ModeLoad       = 1'b0;
  localparam logic       ModeStep       = 1'b1;

  localparam logic [7:0] CmdColumnSet   = 8'h2A;
  localparam logic [7:0] CmdRowSet      = 8'h2B;
  localparam logic [7:0] CmdMemoryWrite = 8'h2C;

  localparam int         BytesPerPixel  = 14;
  localparam int         IdxW           = $clog2(BytesPerPixel);

  typedef logic [IdxW-1:0] idx_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] end_x;
    logic [15:0] end_y;
    logic [15:0] pixel_color;
  } lrwc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last_of_pixel;
    logic       line_done;
  } lrwc_out_t;

  // one pixel handed from the stepper to the serializer
  typedef struct packed {
    logic [15:0] col;
    logic [15:0] row;
    logic [15:0] color;
    logic        done;
  } lrwc_pixel_t;

endpackage

`default_nettype wire

// ===== src/lrwc_stepper.sv =====
// Line state registers and the Bresenham position and error update.
`default_nettype none

module lrwc_stepper (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   accept,
  input  lrwc_pkg::lrwc_in_t    in_word,
  output logic                  pix_valid,
  output lrwc_pkg::lrwc_pixel_t pix
);
  import lrwc_pkg::*;

  logic [15:0] cur_col_r, cur_col_nxt;
  logic [15:0] cur_row_r, cur_row_nxt;
  logic [15:0] goal_col_r, goal_col_nxt;
  logic [15:0] goal_row_r, goal_row_nxt;
  logic [15:0] delta_col_r, delta_col_nxt;
  logic [15:0] delta_row_r, delta_row_nxt;
  logic        col_dir_neg_r, col_dir_neg_nxt;
  logic        row_dir_neg_r, row_dir_neg_nxt;
  logic [17:0] error_term_r, error_term_nxt;
  logic [15:0] line_color_r, line_color_nxt;
  logic        line_active_r, line_active_nxt;

  logic        done;
  logic        col_lt, row_lt;
  logic [15:0] ld_dcol, ld_drow;
  logic [19:0] e2, dc_ext, ndr_ext, err_sum;
  logic        move_col, move_row;

  assign done = (cur_col_r == goal_col_r) && (cur_row_r == goal_row_r);

  assign col_lt  = in_word.start_x < in_word.end_x;
  assign row_lt  = in_word.start_y < in_word.end_y;
  assign ld_dcol = col_lt ? in_word.end_x - in_word.start_x : in_word.start_x - in_word.end_x;
  assign ld_drow = row_lt ? in_word.end_y - in_word.start_y : in_word.start_y - in_word.end_y;

  // e2 = 2 * error, compared against -delta_row and delta_col
  assign e2       = {{1{error_term_r[17]}}, error_term_r, 1'b0};
  assign dc_ext   = {4'b0, delta_col_r};
  assign ndr_ext  = 20'(-{4'b0, delta_row_r});
  assign move_col = $signed(e2) > $signed(ndr_ext);
  assign move_row = $signed(e2) < $signed(dc_ext);
  assign err_sum  = {{2{error_term_r[17]}}, error_term_r}
                  + (move_col ? ndr_ext : 20'd0)
                  + (move_row ? dc_ext : 20'd0);

  assign pix_valid = accept && (in_word.mode == ModeStep) && line_active_r;
  assign pix.col   = cur_col_r;
  assign pix.row   = cur_row_r;
  assign pix.color = line_color_r;
  assign pix.done  = done;

  always_comb begin
    cur_col_nxt     = cur_col_r;
    cur_row_nxt     = cur_row_r;
    goal_col_nxt    = goal_col_r;
    goal_row_nxt    = goal_row_r;
    delta_col_nxt   = delta_col_r;
    delta_row_nxt   = delta_row_r;
    col_dir_neg_nxt = col_dir_neg_r;
    row_dir_neg_nxt = row_dir_neg_r;
    error_term_nxt  = error_term_r;
    line_color_nxt  = line_color_r;
    line_active_nxt = line_active_r;
    if (accept && (in_word.mode == ModeLoad)) begin
      cur_col_nxt     = in_word.start_x;
      cur_row_nxt     = in_word.start_y;
      goal_col_nxt    = in_word.end_x;
      goal_row_nxt    = in_word.end_y;
      delta_col_nxt   = ld_dcol;
      delta_row_nxt   = ld_drow;
      col_dir_neg_nxt = !col_lt;
      row_dir_neg_nxt = !row_lt;
      error_term_nxt  = {2'b0, ld_dcol} - {2'b0, ld_drow};
      line_color_nxt  = in_word.pixel_color;
      line_active_nxt = 1'b1;
    end else if (pix_valid) begin
      if (done) begin
        line_active_nxt = 1'b0;
      end else begin
        error_term_nxt = err_sum[17:0];
        if (move_col) begin
          cur_col_nxt = col_dir_neg_r ? cur_col_r - 16'd1 : cur_col_r + 16'd1;
        end
        if (move_row) begin
          cur_row_nxt = row_dir_neg_r ? cur_row_r - 16'd1 : cur_row_r + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r     <= '0;
      cur_row_r     <= '0;
      goal_col_r    <= '0;
      goal_row_r    <= '0;
      delta_col_r   <= '0;
      delta_row_r   <= '0;
      col_dir_neg_r <= 1'b0;
      row_dir_neg_r <= 1'b0;
      error_term_r  <= '0;
      line_color_r  <= '0;
      line_active_r <= 1'b0;
    end else begin
      cur_col_r     <= cur_col_nxt;
      cur_row_r     <= cur_row_nxt;
      goal_col_r    <= goal_col_nxt;
      goal_row_r    <= goal_row_nxt;
      delta_col_r   <= delta_col_nxt;
      delta_row_r   <= delta_row_nxt;
      col_dir_neg_r <= col_dir_neg_nxt;
      row_dir_neg_r <= row_dir_neg_nxt;
      error_term_r  <= error_term_nxt;
      line_color_r  <= line_color_nxt;
      line_active_r <= line_active_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/lrwc_serializer.sv =====
// Pixel holding slot and the fourteen-byte command/data sequencer.
`default_nettype none

module lrwc_serializer (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   pix_valid,
  input  lrwc_pkg::lrwc_pixel_t pix,
  output logic                  pend_free,
  output logic                  out_valid,
  input  wire                   out_ready,
  output lrwc_pkg::lrwc_out_t   out_word
);
  import lrwc_pkg::*;

  localparam idx_t IdxColCmd  = idx_t'(0);
  localparam idx_t IdxColHi0  = idx_t'(1);
  localparam idx_t IdxColLo0  = idx_t'(2);
  localparam idx_t IdxColHi1  = idx_t'(3);
  localparam idx_t IdxColLo1  = idx_t'(4);
  localparam idx_t IdxRowCmd  = idx_t'(5);
  localparam idx_t IdxRowHi0  = idx_t'(6);
  localparam idx_t IdxRowLo0  = idx_t'(7);
  localparam idx_t IdxRowHi1  = idx_t'(8);
  localparam idx_t IdxRowLo1  = idx_t'(9);
  localparam idx_t IdxWrCmd0  = idx_t'(10);
  localparam idx_t IdxWrCmd1  = idx_t'(11);
  localparam idx_t IdxColorHi = idx_t'(12);
  localparam idx_t IdxColorLo = idx_t'(BytesPerPixel - 1);

  logic        pend_valid_r, pend_valid_nxt;
  lrwc_pixel_t pend_r;
  logic        busy_r, busy_nxt;
  lrwc_pixel_t pix_r;
  idx_t        idx_r, idx_nxt;

  logic fire, last, load_pix;

  assign fire     = busy_r && out_ready;
  assign last     = idx_r == IdxColorLo;
  assign load_pix = pend_valid_r && (!busy_r || (fire && last));

  assign pend_free = !pend_valid_r;
  assign out_valid = busy_r;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (pix_valid) begin
      pend_valid_nxt = 1'b1;
    end else if (load_pix) begin
      pend_valid_nxt = 1'b0;
    end
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load_pix) begin
      busy_nxt = 1'b1;
      idx_nxt  = IdxColCmd;
    end else if (fire) begin
      if (last) begin
        busy_nxt = 1'b0;
      end
      idx_nxt = idx_r + idx_t'(1);
    end
  end

  always_comb begin
    out_word = '0;
    unique case (idx_r)
      IdxColCmd: begin
        out_word.out_byte = CmdColumnSet;
      end
      IdxColHi0, IdxColHi1: begin
        out_word.out_byte = pix_r.col[15:8];
        out_word.is_data  = 1'b1;
      end
      IdxColLo0, IdxColLo1: begin
        out_word.out_byte = pix_r.col[7:0];
        out_word.is_data  = 1'b1;
      end
      IdxRowCmd: begin
        out_word.out_byte = CmdRowSet;
      end
      IdxRowHi0, IdxRowHi1: begin
        out_word.out_byte = pix_r.row[15:8];
        out_word.is_data  = 1'b1;
      end
      IdxRowLo0, IdxRowLo1: begin
        out_word.out_byte = pix_r.row[7:0];
        out_word.is_data  = 1'b1;
      end
      IdxWrCmd0, IdxWrCmd1: begin
        out_word.out_byte = CmdMemoryWrite;
      end
      IdxColorHi: begin
        out_word.out_byte = pix_r.color[15:8];
        out_word.is_data  = 1'b1;
      end
      IdxColorLo: begin
        out_word.out_byte      = pix_r.color[7:0];
        out_word.is_data       = 1'b1;
        out_word.last_of_pixel = 1'b1;
        out_word.line_done     = pix_r.done;
      end
      default: begin
        out_word = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      busy_r       <= 1'b0;
      idx_r        <= IdxColCmd;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      busy_r       <= busy_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid) begin
      pend_r <= pix;
    end
    if (load_pix) begin
      pix_r <= pend_r;
    end
  end

endmodule

`default_nettype wire

// ===== src/line_raster_window_commands.sv =====
// Top level: line rasterizer that streams column/row window and pixel bytes.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+---------------------
//   in_     | input     | in_valid / in_ready    | lrwc_in_t  (load or step)
//   out_    | output    | out_valid / out_ready  | lrwc_out_t (one byte)
//
// A load word yields no bytes. A step word on an active line yields 14 bytes,
// one per cycle at the out port while out_ready stays high.
// A step is taken into a one-pixel holding slot while the previous pixel's bytes
// still go out; in_ready drops only while that slot is occupied.
// Reset clears the line (no line active) and empties the slot and the sequencer.
// out_ready low holds the current byte; the input stalls once the slot is full.
`default_nettype none

module line_raster_window_commands (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  lrwc_pkg::lrwc_in_t  in_word,
  output logic                out_valid,
  input  wire                 out_ready,
  output lrwc_pkg::lrwc_out_t out_word
);
  import lrwc_pkg::*;

  logic        accept;
  logic        pix_valid;
  lrwc_pixel_t pix;

  assign accept = in_valid && in_ready;

  lrwc_stepper u_stepper (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_word   (in_word),
    .pix_valid (pix_valid),
    .pix       (pix)
  );

  lrwc_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix       (pix),
    .pend_free (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

`ifndef SYNTH
  // a pixel handed over always fills the slot, so the next word must wait
  a_slot_fills: assert property (@(posedge clk) disable iff (!rst_n)
    pix_valid |=> !in_ready)
    else $error("pixel handed over but slot not marked full");

  // the bytes of one pixel go out without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_word.last_of_pixel |=> out_valid)
    else $error("gap inside a pixel's byte run");

  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.line_done |-> out_word.last_of_pixel && out_word.is_data)
    else $error("done mark away from the final byte of a pixel");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the line raster window command block.
`timescale 1ns / 100ps

module testbench;
  import lrwc_pkg::*;

  localparam int QuietLimit = 3000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 40;
  localparam int WordsPerStage = 30;

  // Predicts the byte stream of the rasterizer and checks the words that come out.
  class line_byte_scoreboard;
    logic [15:0] col, row, goal_col, goal_row, span_col, span_row, color;
    logic col_back, row_back, armed;
    logic signed [17:0] err;
    lrwc_out_t expected_bytes[$];
    int loads_seen, pixels_painted, bytes_checked, errors;

    function new();
      col = '0; row = '0; goal_col = '0; goal_row = '0;
      span_col = '0; span_row = '0; color = '0;
      col_back = 1'b0; row_back = 1'b0; armed = 1'b0;
      err = '0;
      loads_seen = 0; pixels_painted = 0; bytes_checked = 0; errors = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void push_byte(logic [7:0] b, logic data, logic last, logic done);
      lrwc_out_t e;
      e.out_byte = b;
      e.is_data = data;
      e.last_of_pixel = last;
      e.line_done = done;
      expected_bytes.push_back(e);
    endfunction

    function void note_word(lrwc_in_t w);
      logic done;
      int e2, dc, dr, ne;
      if (w.mode == ModeLoad) begin
        col = w.start_x; row = w.start_y;
        goal_col = w.end_x; goal_row = w.end_y;
        span_col = (w.start_x < w.end_x) ? w.end_x - w.start_x : w.start_x - w.end_x;
        span_row = (w.start_y < w.end_y) ? w.end_y - w.start_y : w.start_y - w.end_y;
        col_back = !(w.start_x < w.end_x);
        row_back = !(w.start_y < w.end_y);
        ne = int'(span_col) - int'(span_row);
        err = ne[17:0];
        color = w.pixel_color;
        armed = 1'b1;
        loads_seen++;
      end else if (armed) begin
        done = (col == goal_col) && (row == goal_row);
        push_byte(CmdColumnSet, 1'b0, 1'b0, 1'b0);
        push_byte(col[15:8], 1'b1, 1'b0, 1'b0);
        push_byte(col[7:0], 1'b1, 1'b0, 1'b0);
        push_byte(col[15:8], 1'b1, 1'b0, 1'b0);
        push_byte(col[7:0], 1'b1, 1'b0, 1'b0);
        push_byte(CmdRowSet, 1'b0, 1'b0, 1'b0);
        push_byte(row[15:8], 1'b1, 1'b0, 1'b0);
        push_byte(row[7:0], 1'b1, 1'b0, 1'b0);
        push_byte(row[15:8], 1'b1, 1'b0, 1'b0);
        push_byte(row[7:0], 1'b1, 1'b0, 1'b0);
        push_byte(CmdMemoryWrite, 1'b0, 1'b0, 1'b0);
        push_byte(CmdMemoryWrite, 1'b0, 1'b0, 1'b0);
        push_byte(color[15:8], 1'b1, 1'b0, 1'b0);
        push_byte(color[7:0], 1'b1, 1'b1, done);
        pixels_painted++;
        if (done) begin
          armed = 1'b0;
        end else begin
          e2 = 2 * int'(err);
          dc = int'(span_col);
          dr = int'(span_row);
          ne = int'(err);
          if (e2 > -dr) begin
            ne -= dr;
            col = col_back ? col - 16'd1 : col + 16'd1;
          end
          if (e2 < dc) begin
            ne += dc;
            row = row_back ? row - 16'd1 : row + 16'd1;
          end
          err = ne[17:0];
        end
      end
    endfunction

    function void check_byte(lrwc_out_t got);
      lrwc_out_t want;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        if (errors < 10)
          $display("unexpected word: byte %02h data %0b last %0b done %0b",
                   got.out_byte, got.is_data, got.last_of_pixel, got.line_done);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.is_data !== want.is_data ||
          got.last_of_pixel !== want.last_of_pixel || got.line_done !== want.line_done) begin
        if (errors < 10)
          $display({"mismatch: want byte %02h data %0b last %0b done %0b, ",
                    "got byte %02h data %0b last %0b done %0b"},
                   want.out_byte, want.is_data, want.last_of_pixel, want.line_done,
                   got.out_byte, got.is_data, got.last_of_pixel, got.line_done);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lrwc_in_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lrwc_out_t out_word;

  int tx_idle_pct = 23;
  int rx_idle_pct = 68;
  int hold_asks = 0;
  int words_sent = 0;

  line_byte_scoreboard sb = new();

  line_raster_window_commands u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_word(in_word);
      if (out_valid && out_ready) sb.check_byte(out_word);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int held, taken;
    held = 0;
    taken = 0;
    forever begin
      @(posedge clk);
      if (taken != hold_asks) begin
        taken = hold_asks;
        held = HoldCycles;
      end
      if (held > 0) begin
        out_ready <= 1'b0;
        held--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no word moved for %0d cycles", QuietLimit);
    $display("Verification failed");
    $finish;
  end

  task automatic send_word(lrwc_in_t w);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_load(int sx, int sy, int ex, int ey, int c);
    lrwc_in_t w;
    w.mode = ModeLoad;
    w.start_x = sx[15:0];
    w.start_y = sy[15:0];
    w.end_x = ex[15:0];
    w.end_y = ey[15:0];
    w.pixel_color = c[15:0];
    send_word(w);
  endtask

  // step payload is don't-care, so it carries random bits
  task automatic send_steps(int n);
    lrwc_in_t w;
    logic [95:0] rnd;
    repeat (n) begin
      rnd = {$urandom, $urandom, $urandom};
      w = rnd[$bits(lrwc_in_t)-1:0];
      w.mode = ModeStep;
      send_word(w);
    end
  endtask

  task automatic draw_line(int sx, int sy, int ex, int ey, int c, int n);
    send_load(sx, sy, ex, ey, c);
    send_steps(n);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic int clamp16(int v);
    return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
  endfunction

  task automatic random_burst();
    int kind, sx, sy, ex, ey, dx, dy, npix, n;
    kind = $urandom_range(0, 9);
    sx = $urandom_range(0, 65535);
    sy = $urandom_range(0, 65535);
    if (kind == 0) begin
      send_steps(1);
    end else if (kind == 1) begin
      // long line that is abandoned by the next load
      draw_line(sx, sy, $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(1, 4));
    end else begin
      ex = clamp16(sx + $urandom_range(0, 12) - 6);
      ey = clamp16(sy + $urandom_range(0, 12) - 6);
      dx = (ex > sx) ? ex - sx : sx - ex;
      dy = (ey > sy) ? ey - sy : sy - ey;
      npix = ((dx > dy) ? dx : dy) + 1;
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, npix);
      else n = npix + $urandom_range(0, 1);
      draw_line(sx, sy, ex, ey, $urandom_range(0, 65535), n);
    end
  endtask

  initial begin
    int target;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: step with no line, single-pixel lines, each direction, extremes
    send_steps(1);
    draw_line(5, 5, 5, 5, 16'hFFFF, 2);
    draw_line(0, 0, 3, 1, 16'h0000, 4);
    draw_line(65535, 65535, 65533, 65535, 16'hA5C3, 3);
    draw_line(0, 65535, 0, 65533, 16'h5A3C, 3);
    draw_line(10, 10, 8, 15, 16'h8001, 6);
    draw_line(0, 0, 65535, 65535, 16'h7FFE, 2);
    // reload while the previous line is still active
    draw_line(65535, 0, 0, 65535, 16'hFFFF, 2);
    draw_line(65535, 65535, 65535, 65535, 16'h0000, 1);
    wait_drained();

    for (int stage = 0; stage < 3; stage++) begin
      tx_idle_pct = (stage == 0) ? 23 : (stage == 1) ? 68 : 0;
      rx_idle_pct = (stage == 0) ? 68 : (stage == 1) ? 23 : 0;
      if (stage == 2) begin
        // output held off while steps keep coming, so the input must stall
        hold_asks++;
        draw_line(100, 200, 119, 205, $urandom_range(0, 65535), 20);
      end
      target = words_sent + WordsPerStage;
      while (words_sent < target) random_burst();
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0d expected bytes never arrived", sb.pending());
      sb.errors++;
    end
    $display("Sent %0d words: %0d line loads, %0d pixels, %0d bytes checked",
             words_sent, sb.loads_seen, sb.pixels_painted, sb.bytes_checked);
    $display("Stalls on both sides, a long output hold-off and a full drain pause were exercised");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
